[rtl/srsw_pkg.sv]
// shared types and constants of the selective-repeat sender window
// no dependencies
package srsw_pkg;

  localparam int FRAME_COUNT_W = 5;
  localparam int WINDOW_SIZE_W = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int OP_W          = 2;
  localparam int SEQ_W         = 4;

  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 5'd12;
  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 4'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_COUNT = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLIDE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic mark_ack;
    logic slide_step;
    logic scan_init;
    logic scan_step;
    logic pend_load;
    logic emit_frame;
    logic emit_last;
    logic emit_status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ack_ok;
    logic slide_more;
    logic scan_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/srsw_in_if.sv]
// input channel: event word with valid/ready handshake
// depends on srsw_pkg
interface srsw_in_if;
  import srsw_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SEQ_W-1:0] ack_number;

  modport source (output valid, output operation, output ack_number, input ready);
  modport sink (input valid, input operation, input ack_number, output ready);
endinterface

[rtl/srsw_out_if.sv]
// result channel: frame order or status word with valid/ready handshake
// depends on srsw_pkg
interface srsw_out_if;
  import srsw_pkg::*;

  logic             valid;
  logic             ready;
  logic             frame_valid;
  logic [SEQ_W-1:0] frame_number;
  logic             is_resend;
  logic             all_acked;
  logic             last;

  modport source (output valid, output frame_valid, output frame_number,
                  output is_resend, output all_acked, output last, input ready);
  modport sink (input valid, input frame_valid, input frame_number,
                input is_resend, input all_acked, input last, output ready);
endinterface

[rtl/srsw_ctrl.sv]
// controller state machine: decode, base slide, window scan, flush
// depends on srsw_pkg
module srsw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srsw_pkg::dp_status_t sts,
  output srsw_pkg::dp_cmd_t    cmd
);
  import srsw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op == OP_ACK && sts.ack_ok) begin
          cmd.mark_ack = 1'b1;
          state_nxt    = ST_SLIDE;
        end else if (sts.op == OP_START || sts.op == OP_TIMEOUT) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SLIDE: begin
        if (sts.slide_more) begin
          cmd.slide_step = 1'b1;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FLUSH;
        end else if (!sts.hit) begin
          cmd.scan_step = 1'b1;
        end else if (!sts.pend_valid) begin
          cmd.pend_load = 1'b1;
          cmd.scan_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_frame = 1'b1;
          cmd.pend_load  = 1'b1;
          cmd.scan_step  = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_frame  = sts.pend_valid;
          cmd.emit_last   = sts.pend_valid;
          cmd.emit_status = !sts.pend_valid;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/srsw_dp.sv]
// datapath: config registers, window base, mark vectors, scan pointer,
// pending frame and output register; depends on srsw_pkg
module srsw_dp #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_WINDOW = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [srsw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [srsw_pkg::OP_W-1:0]          in_operation,
  input  logic [srsw_pkg::SEQ_W-1:0]         in_ack_number,
  input  srsw_pkg::dp_cmd_t                  cmd,
  output srsw_pkg::dp_status_t               sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_frame_valid,
  output logic [srsw_pkg::SEQ_W-1:0]         out_frame_number,
  output logic                               out_is_resend,
  output logic                               out_all_acked,
  output logic                               out_last
);
  import srsw_pkg::*;

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int PW = $clog2(MAX_FRAMES + MAX_WINDOW + 1);

  logic [FRAME_COUNT_W-1:0] fc_r, fc_nxt;
  logic [WINDOW_SIZE_W-1:0] ws_r, ws_nxt;
  op_t                      op_r, op_nxt;
  logic [SEQ_W-1:0]         ack_r, ack_nxt;
  logic [PW-1:0]            base_r, base_nxt;
  logic [PW-1:0]            scan_r, scan_nxt;
  logic [MAX_FRAMES-1:0]    acked_r, acked_nxt;
  logic [MAX_FRAMES-1:0]    sent_r, sent_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [SEQ_W-1:0]         pend_num_r, pend_num_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     ofv_r, ofv_nxt;
  logic [SEQ_W-1:0]         onum_r, onum_nxt;
  logic                     ores_r, ores_nxt;
  logic                     oall_r, oall_nxt;
  logic                     olast_r, olast_nxt;

  logic [PW-1:0] eff_fc, eff_ws, win_sum, win_end;
  logic [IW-1:0] scan_idx, base_idx, ack_idx;
  logic          all_acked, out_free;

  always_comb begin
    eff_fc    = (int'(fc_r) > MAX_FRAMES) ? PW'(MAX_FRAMES) : PW'(fc_r);
    eff_ws    = (int'(ws_r) > MAX_WINDOW) ? PW'(MAX_WINDOW) : PW'(ws_r);
    win_sum   = base_r + eff_ws;
    win_end   = (win_sum > eff_fc) ? eff_fc : win_sum;
    scan_idx  = scan_r[IW-1:0];
    base_idx  = base_r[IW-1:0];
    ack_idx   = IW'(ack_r);
    all_acked = (base_r >= eff_fc);
    out_free  = !out_valid_r || out_ready;

    sts.op         = op_r;
    sts.ack_ok     = (int'(ack_r) < int'(eff_fc));
    sts.slide_more = (base_r < eff_fc) && acked_r[base_idx];
    sts.scan_done  = (scan_r >= win_end);
    sts.hit        = (op_r == OP_TIMEOUT) ? !acked_r[scan_idx] : !sent_r[scan_idx];
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  always_comb begin
    fc_nxt         = fc_r;
    ws_nxt         = ws_r;
    op_nxt         = op_r;
    ack_nxt        = ack_r;
    base_nxt       = base_r;
    scan_nxt       = scan_r;
    acked_nxt      = acked_r;
    sent_nxt       = sent_r;
    pend_valid_nxt = pend_valid_r;
    pend_num_nxt   = pend_num_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ofv_nxt        = ofv_r;
    onum_nxt       = onum_r;
    ores_nxt       = ores_r;
    oall_nxt       = oall_r;
    olast_nxt      = olast_r;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_COUNT: fc_nxt = cfg_data[FRAME_COUNT_W-1:0];
        REG_WINDOW_SIZE: ws_nxt = cfg_data[WINDOW_SIZE_W-1:0];
        default: ;
      endcase
    end

    if (cmd.latch_in) begin
      op_nxt  = op_t'(in_operation);
      ack_nxt = in_ack_number;
    end
    if (cmd.mark_ack) begin
      acked_nxt[ack_idx] = 1'b1;
    end
    if (cmd.slide_step) begin
      base_nxt = base_r + PW'(1);
    end
    if (cmd.scan_init) begin
      scan_nxt = base_r;
    end
    if (cmd.scan_step) begin
      scan_nxt = scan_r + PW'(1);
    end

    if (cmd.emit_frame) begin
      out_valid_nxt = 1'b1;
      ofv_nxt       = 1'b1;
      onum_nxt      = pend_num_r;
      ores_nxt      = (op_r == OP_TIMEOUT);
      oall_nxt      = all_acked;
      olast_nxt     = cmd.emit_last;
      if (cmd.emit_last) begin
        pend_valid_nxt = 1'b0;
      end
    end
    if (cmd.emit_status) begin
      out_valid_nxt = 1'b1;
      ofv_nxt       = 1'b0;
      onum_nxt      = '0;
      ores_nxt      = 1'b0;
      oall_nxt      = all_acked;
      olast_nxt     = 1'b1;
    end
    if (cmd.pend_load) begin
      pend_valid_nxt     = 1'b1;
      pend_num_nxt       = SEQ_W'(scan_r);
      sent_nxt[scan_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r         <= FRAME_COUNT_RST;
      ws_r         <= WINDOW_SIZE_RST;
      op_r         <= OP_NONE;
      base_r       <= '0;
      scan_r       <= '0;
      acked_r      <= '0;
      sent_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fc_r         <= fc_nxt;
      ws_r         <= ws_nxt;
      op_r         <= op_nxt;
      base_r       <= base_nxt;
      scan_r       <= scan_nxt;
      acked_r      <= acked_nxt;
      sent_r       <= sent_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ack_r      <= ack_nxt;
    pend_num_r <= pend_num_nxt;
    ofv_r      <= ofv_nxt;
    onum_r     <= onum_nxt;
    ores_r     <= ores_nxt;
    oall_r     <= oall_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_valid  = ofv_r;
  assign out_frame_number = onum_r;
  assign out_is_resend    = ores_r;
  assign out_all_acked    = oall_r;
  assign out_last         = olast_r;

endmodule

[rtl/selective_repeat_sender_window_top.sv]
// steps: accept, decode, slide the base on an ack that moves it k places, scan
// the w window positions, flush; start or timeout skips the slide, a status-only
// word goes from decode to flush; one event word in flight at a time; the window
// scan visits one mark per cycle, held on a hit while pending and output are full
// synchronous active-low reset clears base and marks, loads default config, empties
// handshake state; depends on srsw_pkg, srsw_in_if, srsw_out_if, srsw_ctrl, srsw_dp
module selective_repeat_sender_window_top #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_WINDOW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  srsw_in_if.sink                          in_if,
  srsw_out_if.source                       out_if
);
  import srsw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srsw_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_if.operation),
    .in_ack_number    (in_if.ack_number),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_frame_valid  (out_if.frame_valid),
    .out_frame_number (out_if.frame_number),
    .out_is_resend    (out_if.is_resend),
    .out_all_acked    (out_if.all_acked),
    .out_last         (out_if.last)
  );

endmodule
